>>> rtl/core/tccs_pkg.sv
package tccs_pkg;

  // Default store geometry.
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned DEF_MAX_ROWS = 32;

  // Cell layout: attribute in the high byte, character in the low byte.
  localparam int unsigned CELL_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 2'd2;

  localparam logic [7:0] RST_WIDTH  = 8'd80;
  localparam logic [5:0] RST_HEIGHT = 6'd25;
  localparam logic [7:0] RST_ATTR   = 8'd7;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] TAB_SPACES = 3'd4;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_OUT_OF_WIN = 1'b1;

  typedef enum logic [2:0] {
    ACT_PUT    = 3'd0,
    ACT_SET    = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_SCROLL = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       scrolled;
    logic       status;
  } out_item_t;

  // Effective window settings, already clamped to the store size.
  typedef struct packed {
    logic [7:0] width;
    logic [5:0] height;
    logic [7:0] attr;
  } cfg_t;

endpackage

>>> rtl/core/tccs_stream_if.sv
interface tccs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/text_console_cursor_scroll_core.sv
// Text-window console engine with a character/attribute cell store and a cursor.
// Commands arrive on in_i as valid/ready transactions (action, char_code, row,
// col); every command returns exactly one result transaction on out_o with the
// cursor after the command, the cell read, a scrolled flag and a status bit.
// Window width, height and attribute are written through the cfg_* port; the user
// must write them only while the engine is idle, which the block does not enforce.
// After reset the engine sweeps all MAX_ROWS * MAX_COLS cells (4096 by default)
// of the store to zero, one cell per cycle; in_i.ready stays low meanwhile.
// The engine works on one command at a time: it accepts a command, then works in
// the cell memory, which has one write and one read port. A printable byte writes
// its cell; CR, LF, BS and set cursor move the cursor (BS also blanks a cell); a
// read fetches a cell; a tab writes four spaces; clear blanks every window cell;
// scroll copies each line one row up, then blanks the last line (only the blank
// on a one-line window). A command that wraps past the end scrolls the same way.
// The result sits in an output register, so a new command is accepted while it
// waits. When out_o stalls, a finished command holds in the engine until the
// register is free.
module text_console_cursor_scroll_core #(
  parameter int unsigned MAX_COLS = tccs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tccs_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tccs_stream_if.sink                     in_i,
  tccs_stream_if.source                   out_o,
  input  logic                            cfg_we_i,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tccs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tccs_pkg::*;

  cfg_t       cfg;
  logic       seq_ready;
  logic       res_valid;
  logic       res_ready;
  out_item_t  res;
  in_item_t   item;

  logic       out_valid_q;
  out_item_t  out_q;

  assign item = in_i.payload;

  tccs_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tccs_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_i.valid),
    .item_ready_o (seq_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign in_i.ready = seq_ready;
  assign res_ready  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_valid_q && !out_o.ready) |=> (out_q == $past(out_q)))
    else $error("pending result overwritten");

  // The reported cursor always lies inside the window.
  a_cursor_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.cursor_row < cfg.height) && (out_q.cursor_col < cfg.width)))
    else $error("cursor outside window");

  // A rejected position never comes with a scroll or with cell data.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == STATUS_OUT_OF_WIN)) |->
      (!out_q.scrolled && (out_q.read_char == 8'd0) && (out_q.read_attr == 8'd0)))
    else $error("rejected command with side effects");

  // No command is taken while a finished one still waits inside the engine.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |-> !in_i.ready)
    else $error("command accepted while result pending in engine");

endmodule

>>> rtl/core/tccs_ram.sv
module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tccs_cfg.sv
module tccs_cfg #(
  parameter int unsigned MAX_COLS = tccs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tccs_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output tccs_pkg::cfg_t                     cfg_o
);
  import tccs_pkg::*;

  // Largest values the register fields can reach, capped by the store.
  localparam logic [7:0] W_CAP = (MAX_COLS > 255) ? 8'd255 : 8'(MAX_COLS);
  localparam logic [5:0] H_CAP = (MAX_ROWS > 63) ? 6'd63 : 6'(MAX_ROWS);

  logic [7:0] width_q;
  logic [5:0] height_q;
  logic [7:0] attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      attr_q   <= RST_ATTR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i[7:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[5:0];
        CFG_ATTR:   attr_q   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_q == 8'd0) begin
      cfg_o.width = 8'd1;
    end else if (width_q > W_CAP) begin
      cfg_o.width = W_CAP;
    end else begin
      cfg_o.width = width_q;
    end

    if (height_q == 6'd0) begin
      cfg_o.height = 6'd1;
    end else if (height_q > H_CAP) begin
      cfg_o.height = H_CAP;
    end else begin
      cfg_o.height = height_q;
    end

    cfg_o.attr = attr_q;
  end

endmodule

>>> rtl/core/tccs_seq.sv
module tccs_seq #(
  parameter int unsigned MAX_COLS = tccs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tccs_pkg::DEF_MAX_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tccs_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  tccs_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tccs_pkg::out_item_t res_o
);
  import tccs_pkg::*;

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CTRL,
    ST_PUT,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [2:0]         act_q, act_d;
  logic [7:0]         ch_q, ch_d;
  logic [4:0]         rr_q, rr_d;
  logic [6:0]         rc_q, rc_d;
  logic [7:0]         put_ch_q, put_ch_d;
  logic [2:0]         left_q, left_d;
  logic               scr_q, scr_d;
  logic               bad_q, bad_d;
  logic [7:0]         rd_ch_q, rd_ch_d;
  logic [7:0]         rd_at_q, rd_at_d;
  logic [ROW_W-1:0]   sw_row_q, sw_row_d;
  logic [COL_W-1:0]   sw_col_q, sw_col_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic [ADDR_W-1:0]  init_addr_q, init_addr_d;

  logic               fin;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic [ROW_W-1:0]   h_last;
  logic [COL_W-1:0]   w_last;
  logic [CELL_W-1:0]  blank_cell;
  logic               in_out_of_win;
  logic               set_out_of_win;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r * MAX_COLS) + ADDR_W'(c);
  endfunction

  assign h_last         = ROW_W'(cfg_i.height - 6'd1);
  assign w_last         = COL_W'(cfg_i.width - 8'd1);
  assign blank_cell     = {cfg_i.attr, CH_SPACE};
  assign in_out_of_win  = (item_i.row >= cfg_i.height) || (item_i.col >= cfg_i.width);
  assign set_out_of_win = (rr_q >= cfg_i.height) || (rc_q >= cfg_i.width);

  assign item_ready_o = (state_q == ST_IDLE);

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    act_d       = act_q;
    ch_d        = ch_q;
    rr_d        = rr_q;
    rc_d        = rc_q;
    put_ch_d    = put_ch_q;
    left_d      = left_q;
    scr_d       = scr_q;
    bad_d       = bad_q;
    rd_ch_d     = rd_ch_q;
    rd_at_d     = rd_at_q;
    sw_row_d    = sw_row_q;
    sw_col_d    = sw_col_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    init_addr_d = init_addr_q;
    fin         = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = cell_addr(cur_row_q, cur_col_q);
    ram_wdata = blank_cell;
    ram_raddr = cell_addr(sw_row_q, sw_col_q);

    // A cell read during the line copy is written one row up in the next cycle.
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end

    case (state_q)
      ST_INIT: begin
        ram_we      = 1'b1;
        ram_waddr   = init_addr_q;
        ram_wdata   = '0;
        init_addr_d = init_addr_q + ADDR_W'(1);
        if (init_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = cell_addr(ROW_W'(item_i.row), COL_W'(item_i.col));
        if (item_valid_i) begin
          act_d    = item_i.action;
          ch_d     = item_i.char_code;
          rr_d     = item_i.row;
          rc_d     = item_i.col;
          scr_d    = 1'b0;
          bad_d    = STATUS_OK;
          rd_ch_d  = '0;
          rd_at_d  = '0;
          sw_row_d = '0;
          sw_col_d = '0;
          // The window may have shrunk since the cursor was placed.
          cur_row_d = (cur_row_q >= cfg_i.height) ? h_last : cur_row_q;
          cur_col_d = (cur_col_q >= cfg_i.width) ? w_last : cur_col_q;
          case (action_e'(item_i.action))
            ACT_PUT: begin
              if (item_i.char_code == CH_TAB) begin
                put_ch_d = CH_SPACE;
                left_d   = TAB_SPACES;
                state_d  = ST_PUT;
              end else if (item_i.char_code >= CH_SPACE) begin
                put_ch_d = item_i.char_code;
                left_d   = 3'd1;
                state_d  = ST_PUT;
              end else begin
                state_d = ST_CTRL;
              end
            end
            ACT_SET:    state_d = ST_CTRL;
            ACT_CLEAR:  state_d = ST_CLEAR;
            ACT_READ: begin
              bad_d   = in_out_of_win ? STATUS_OUT_OF_WIN : STATUS_OK;
              state_d = ST_READ;
            end
            ACT_SCROLL: state_d = ST_SCROLL;
            default:    state_d = ST_CTRL;
          endcase
        end
      end

      ST_CTRL: begin
        fin = 1'b1;
        case (action_e'(act_q))
          ACT_PUT: begin
            if (ch_q == CH_CR) begin
              cur_col_d = '0;
            end else if (ch_q == CH_LF) begin
              cur_col_d = '0;
              if (cur_row_q == h_last) begin
                fin     = 1'b0;
                state_d = ST_SCROLL;
              end else begin
                cur_row_d = cur_row_q + ROW_W'(1);
              end
            end else if (ch_q == CH_BS) begin
              if ((cur_row_q != '0) || (cur_col_q != '0)) begin
                if (cur_col_q == '0) begin
                  cur_row_d = cur_row_q - ROW_W'(1);
                  cur_col_d = w_last;
                end else begin
                  cur_col_d = cur_col_q - COL_W'(1);
                end
                ram_we    = 1'b1;
                ram_waddr = cell_addr(cur_row_d, cur_col_d);
                ram_wdata = blank_cell;
              end
            end
          end
          ACT_SET: begin
            if (set_out_of_win) begin
              bad_d = STATUS_OUT_OF_WIN;
            end else begin
              cur_row_d = ROW_W'(rr_q);
              cur_col_d = COL_W'(rc_q);
            end
          end
          default: begin
          end
        endcase
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(cur_row_q, cur_col_q);
        ram_wdata = {cfg_i.attr, put_ch_q};
        left_d    = left_q - 3'd1;
        if (cur_col_q == w_last) begin
          cur_col_d = '0;
          if (cur_row_q == h_last) begin
            state_d = ST_SCROLL;
          end else begin
            cur_row_d = cur_row_q + ROW_W'(1);
            fin       = (left_d == 3'd0);
          end
        end else begin
          cur_col_d = cur_col_q + COL_W'(1);
          fin       = (left_d == 3'd0);
        end
      end

      ST_READ: begin
        if (bad_q == STATUS_OK) begin
          rd_ch_d = ram_rdata[7:0];
          rd_at_d = ram_rdata[15:8];
        end
        fin = 1'b1;
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(sw_row_q, sw_col_q);
        ram_wdata = blank_cell;
        if (sw_col_q == w_last) begin
          sw_col_d = '0;
          if (sw_row_q == h_last) begin
            cur_row_d = '0;
            cur_col_d = '0;
            fin       = 1'b1;
          end else begin
            sw_row_d = sw_row_q + ROW_W'(1);
          end
        end else begin
          sw_col_d = sw_col_q + COL_W'(1);
        end
      end

      ST_SCROLL: begin
        scr_d     = 1'b1;
        cur_row_d = h_last;
        cur_col_d = '0;
        sw_row_d  = ROW_W'(1);
        sw_col_d  = '0;
        state_d   = (cfg_i.height == 6'd1) ? ST_BLANK : ST_COPY;
      end

      ST_COPY: begin
        pend_d      = 1'b1;
        pend_addr_d = cell_addr(sw_row_q - ROW_W'(1), sw_col_q);
        if (sw_col_q == w_last) begin
          sw_col_d = '0;
          if (sw_row_q == h_last) begin
            state_d = ST_DRAIN;
          end else begin
            sw_row_d = sw_row_q + ROW_W'(1);
          end
        end else begin
          sw_col_d = sw_col_q + COL_W'(1);
        end
      end

      ST_DRAIN: begin
        state_d = ST_BLANK;
      end

      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(h_last, sw_col_q);
        ram_wdata = blank_cell;
        if (sw_col_q == w_last) begin
          sw_col_d = '0;
          if (left_q != 3'd0) begin
            state_d = ST_PUT;
          end else begin
            fin = 1'b1;
          end
        end else begin
          sw_col_d = sw_col_q + COL_W'(1);
        end
      end

      ST_DONE: begin
        fin = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished result waits here while the output register is still full.
    if (fin) begin
      state_d = res_ready_i ? ST_IDLE : ST_DONE;
    end
  end

  assign res_valid_o         = fin;
  assign res_o.cursor_row    = 5'(cur_row_d);
  assign res_o.cursor_col    = 7'(cur_col_d);
  assign res_o.read_char     = rd_ch_d;
  assign res_o.read_attr     = rd_at_d;
  assign res_o.scrolled      = scr_d;
  assign res_o.status        = bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      init_addr_q <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      init_addr_q <= init_addr_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    ch_q        <= ch_d;
    rr_q        <= rr_d;
    rc_q        <= rc_d;
    put_ch_q    <= put_ch_d;
    scr_q       <= scr_d;
    bad_q       <= bad_d;
    rd_ch_q     <= rd_ch_d;
    rd_at_q     <= rd_at_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

>>> tb/tb_text_console_cursor_scroll_core.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_core;
  import tccs_pkg::*;

  localparam int unsigned MAX_COLS = DEF_MAX_COLS;
  localparam int unsigned MAX_ROWS = DEF_MAX_ROWS;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned MAX_PRINTED = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tccs_stream_if #(.T(in_item_t))  cmd_ch ();
  tccs_stream_if #(.T(out_item_t)) res_ch ();

  text_console_cursor_scroll_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow copy of the console: cell store, cursor and window registers.
  logic [CELL_W-1:0] cell_mem [MAX_ROWS*MAX_COLS];
  logic [7:0]        model_width;
  logic [5:0]        model_height;
  logic [7:0]        model_attr;
  int unsigned       cur_row;
  int unsigned       cur_col;

  in_item_t    cmd_queue[$];
  out_item_t   result_queue[$];
  int unsigned issued_count;
  int unsigned accepted_count;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          full_speed;
  out_item_t   predicted;
  out_item_t   want;

  function automatic int unsigned eff_width();
    if (model_width == 0) return 1;
    if (model_width > MAX_COLS) return MAX_COLS;
    return model_width;
  endfunction

  function automatic int unsigned eff_height();
    if (model_height == 0) return 1;
    if (model_height > MAX_ROWS) return MAX_ROWS;
    return model_height;
  endfunction

  // Moves every window line up by one, blanks the last line and parks the cursor there.
  function automatic void shift_up(input int unsigned w, input int unsigned h);
    for (int unsigned r = 0; r + 1 < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        cell_mem[r*MAX_COLS + c] = cell_mem[(r+1)*MAX_COLS + c];
      end
    end
    for (int unsigned c = 0; c < w; c++) begin
      cell_mem[(h-1)*MAX_COLS + c] = {model_attr, CH_SPACE};
    end
    cur_row = h - 1;
    cur_col = 0;
  endfunction

  function automatic bit put_glyph(input logic [7:0] ch, input int unsigned w,
                                   input int unsigned h);
    cell_mem[cur_row*MAX_COLS + cur_col] = {model_attr, ch};
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) begin
        shift_up(w, h);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_console(input in_item_t cmd);
    int unsigned w;
    int unsigned h;
    out_item_t   res;
    bit          scr;
    bit          bad;
    w   = eff_width();
    h   = eff_height();
    res = '0;
    scr = 1'b0;
    bad = 1'b0;
    // A cursor left outside a shrunken window is pulled back to its edge first.
    if (cur_row >= h) cur_row = h - 1;
    if (cur_col >= w) cur_col = w - 1;
    case (cmd.action)
      ACT_PUT: begin
        if (cmd.char_code == CH_CR) begin
          cur_col = 0;
        end else if (cmd.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= h) begin
            shift_up(w, h);
            scr = 1'b1;
          end
        end else if (cmd.char_code == CH_TAB) begin
          for (int i = 0; i < TAB_SPACES; i++) begin
            if (put_glyph(CH_SPACE, w, h)) scr = 1'b1;
          end
        end else if (cmd.char_code == CH_BS) begin
          if (cur_row != 0 || cur_col != 0) begin
            if (cur_col == 0) begin
              cur_row--;
              cur_col = w - 1;
            end else begin
              cur_col--;
            end
            cell_mem[cur_row*MAX_COLS + cur_col] = {model_attr, CH_SPACE};
          end
        end else if (cmd.char_code >= CH_SPACE) begin
          scr = put_glyph(cmd.char_code, w, h);
        end
      end
      ACT_SET: begin
        if (cmd.row >= h || cmd.col >= w) begin
          bad = 1'b1;
        end else begin
          cur_row = cmd.row;
          cur_col = cmd.col;
        end
      end
      ACT_CLEAR: begin
        for (int unsigned r = 0; r < h; r++) begin
          for (int unsigned c = 0; c < w; c++) begin
            cell_mem[r*MAX_COLS + c] = {model_attr, CH_SPACE};
          end
        end
        cur_row = 0;
        cur_col = 0;
      end
      ACT_READ: begin
        if (cmd.row >= h || cmd.col >= w) begin
          bad = 1'b1;
        end else begin
          res.read_char = cell_mem[cmd.row*MAX_COLS + cmd.col][7:0];
          res.read_attr = cell_mem[cmd.row*MAX_COLS + cmd.col][15:8];
        end
      end
      ACT_SCROLL: begin
        shift_up(w, h);
        scr = 1'b1;
      end
      default: begin
      end
    endcase
    res.cursor_row = cur_row[4:0];
    res.cursor_col = cur_col[6:0];
    res.scrolled   = scr;
    res.status     = bad ? STATUS_OUT_OF_WIN : STATUS_OK;
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic in_item_t make_cmd(input logic [2:0] action, input logic [7:0] ch,
                                        input logic [4:0] row, input logic [6:0] col);
    in_item_t c;
    c.action    = action;
    c.char_code = ch;
    c.row       = row;
    c.col       = col;
    return c;
  endfunction

  // Mostly text and control bytes with cursor moves and reads that mostly land inside the
  // window; whole-window actions are kept rare on large windows since they are slow.
  function automatic in_item_t random_cmd(input int unsigned w, input int unsigned h);
    in_item_t    c;
    int unsigned r;
    int unsigned heavy;
    c.action    = ACT_PUT;
    c.char_code = $urandom_range(0, 255);
    c.row       = $urandom_range(0, 31);
    c.col       = $urandom_range(0, 127);
    heavy = (w * h > 512) ? 1 : 4;
    r = $urandom_range(0, 99);
    if (r < 42) begin
      c.char_code = $urandom_range(32, 255);
    end else if (r < 52) begin
      case ($urandom_range(0, 4))
        0: c.char_code = CH_CR;
        1: c.char_code = CH_LF;
        2: c.char_code = CH_TAB;
        3: c.char_code = CH_BS;
        default: c.char_code = $urandom_range(0, 31);
      endcase
    end else if (r < 84) begin
      c.action = (r < 62) ? ACT_SET : ACT_READ;
      if ($urandom_range(0, 4) != 0) begin
        c.row = $urandom_range(0, h - 1);
        c.col = $urandom_range(0, w - 1);
      end
    end else if (r < 84 + heavy) begin
      c.action = ACT_CLEAR;
    end else if (r < 84 + 2 * heavy) begin
      c.action = ACT_SCROLL;
    end else if (r < 92) begin
      c.action = 3'(ACT_SCROLL + $urandom_range(1, 3));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_cmd(input in_item_t c);
    cmd_queue.push_back(c);
    issued_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (accepted_count != issued_count || result_queue.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_WIDTH:  model_width  = data;
      CFG_HEIGHT: model_height = data[5:0];
      CFG_ATTR:   model_attr   = data;
      default: begin
      end
    endcase
  endtask

  task automatic set_window(input logic [7:0] w, input logic [7:0] h, input logic [7:0] attr);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_ATTR, attr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input bit fast);
    int unsigned w;
    int unsigned h;
    @(negedge clk_i);
    w = eff_width();
    h = eff_height();
    full_speed = fast;
    repeat (count) queue_cmd(random_cmd(w, h));
    wait_idle();
  endtask

  // Command driver: predicts each command at the edge where its transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.payload <= '0;
      send_gap       <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted = predict_console(cmd_ch.payload);
        result_queue.push_back(predicted);
        accepted_count++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          cmd_ch.valid   <= 1'b1;
          cmd_ch.payload <= cmd_queue.pop_front();
          send_gap       <= full_speed ? 0 : draw_gap();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and a few long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          want = result_queue.pop_front();
          if (res_ch.payload.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                      res_ch.payload.cursor_row, want.cursor_row));
          if (res_ch.payload.cursor_col !== want.cursor_col)
            report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                      res_ch.payload.cursor_col, want.cursor_col));
          if (res_ch.payload.read_char !== want.read_char)
            report_mismatch($sformatf("read_char got %h expected %h",
                                      res_ch.payload.read_char, want.read_char));
          if (res_ch.payload.read_attr !== want.read_attr)
            report_mismatch($sformatf("read_attr got %h expected %h",
                                      res_ch.payload.read_attr, want.read_attr));
          if (res_ch.payload.scrolled !== want.scrolled)
            report_mismatch($sformatf("scrolled got %b expected %b",
                                      res_ch.payload.scrolled, want.scrolled));
          if (res_ch.payload.status !== want.status)
            report_mismatch($sformatf("status got %b expected %b",
                                      res_ch.payload.status, want.status));
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (res_ch.valid && res_ch.ready &&
                   (results_seen == 150 || results_seen == 420 || results_seen == 700)) begin
        // Long hold-off so the engine fills its output register and stalls commands.
        hold_left    <= 600;
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!full_speed && $urandom_range(0, 3) == 0) stall_left <= draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_WIDTH;
    cfg_wdata_i <= '0;
    quiet_cycles <= 0;
    for (int unsigned i = 0; i < MAX_ROWS * MAX_COLS; i++) cell_mem[i] = '0;
    model_width    = RST_WIDTH;
    model_height   = RST_HEIGHT;
    model_attr     = RST_ATTR;
    cur_row        = 0;
    cur_col        = 0;
    issued_count   = 0;
    accepted_count = 0;
    results_seen   = 0;
    error_count    = 0;
    full_speed     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands on the reset window of 80 x 25.
    @(negedge clk_i);
    queue_cmd(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, 8'h41, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, 8'hFF, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, 8'h7F, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, 8'h01, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, 8'h00, 5'd31, 7'd127));
    queue_cmd(make_cmd(ACT_PUT, CH_TAB, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, CH_BS, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, CH_CR, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, CH_LF, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, CH_BS, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd3, 7'd0));
    queue_cmd(make_cmd(ACT_PUT, CH_BS, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd25, 7'd0));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd0, 7'd80));
    queue_cmd(make_cmd(ACT_READ, 8'h00, 5'd24, 7'd80));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd24, 7'd79));
    queue_cmd(make_cmd(ACT_PUT, 8'h5A, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_SET, 8'h00, 5'd24, 7'd5));
    queue_cmd(make_cmd(ACT_PUT, CH_LF, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_SCROLL, 8'h00, 5'd0, 7'd0));
    queue_cmd(make_cmd(ACT_CLEAR, 8'h00, 5'd0, 7'd0));
    queue_cmd(make_cmd(3'(ACT_SCROLL + 1), 8'hFF, 5'd31, 7'd127));
    queue_cmd(make_cmd(3'(ACT_SCROLL + 3), 8'h00, 5'd0, 7'd0));
    wait_idle();
    run_random(100, 1'b0);

    // Extremes first, including register values that saturate, then mixed and random small windows.
    set_window(8'd1, 8'd1, 8'h00);
    run_random(70, 1'b1);
    set_window(8'd128, 8'd32, 8'hFF);
    run_random(60, 1'b0);
    set_window(8'd0, 8'hC0, 8'h5A);
    run_random(40, 1'b0);
    set_window(8'hFF, 8'hFF, 8'hA5);
    run_random(40, 1'b1);
    set_window(8'd3, 8'd2, 8'h1E);
    run_random(90, 1'b0);
    set_window(8'd16, 8'd8, 8'h70);
    run_random(100, 1'b0);
    set_window(8'd5, 8'd32, 8'h0F);
    run_random(80, 1'b1);
    set_window(8'd128, 8'd1, 8'hC3);
    run_random(60, 1'b0);
    repeat (4) begin
      set_window(8'($urandom_range(1, 24)), 8'($urandom_range(1, 8)),
                 8'($urandom_range(0, 255)));
      run_random(40, 1'b0);
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
